[sv/ism_pkg.sv]
`default_nettype none

package ism_pkg;

    localparam int DATA_W = 32;

    localparam logic [3:0] OP_CONST = 4'd0;
    localparam logic [3:0] OP_ADD   = 4'd1;
    localparam logic [3:0] OP_SUB   = 4'd2;
    localparam logic [3:0] OP_MUL   = 4'd3;
    localparam logic [3:0] OP_DIV   = 4'd4;
    localparam logic [3:0] OP_MAX   = 4'd5;
    localparam logic [3:0] OP_MIN   = 4'd6;
    localparam logic [3:0] OP_NEG   = 4'd7;
    localparam logic [3:0] OP_DUP   = 4'd8;
    localparam logic [3:0] OP_SWAP  = 4'd9;

    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_UNDER   = 2'd1;
    localparam logic [1:0] ERR_OVER    = 2'd2;
    localparam logic [1:0] ERR_DIVZERO = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_RESP
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] num;
        logic [DATA_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quot;
    } div_rsp_t;

endpackage

`default_nettype wire

[sv/ism_stack_ram.sv]
`default_nettype none

module ism_stack_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int WIDTH  = 32
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[sv/ism_divider.sv]
`default_nettype none

module ism_divider
    import ism_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] den_reg, den_next;
    logic              neg_reg, neg_next;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        shifted   = {rem_reg, quo_reg[DATA_W-1]};
        diff      = shifted - {1'b0, den_reg};

        if (req.start)
        begin
            // Work on magnitudes; the sign is applied on the way out.
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.num[DATA_W-1] ? (~req.num + 1'b1) : req.num;
            den_next  = req.den[DATA_W-1] ? (~req.den + 1'b1) : req.den;
            neg_next  = req.num[DATA_W-1] ^ req.den[DATA_W-1];
        end
        else if (busy_reg)
        begin
            if (!diff[DATA_W])
            begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

`default_nettype wire

[sv/integer_stack_machine_top.sv]
// Every operation passes through the EXEC and RESP states after its input
// transfer; DIV also waits in the DIV state for the one-bit-per-cycle divider.
// One instruction at a time; a new input is taken as soon as the previous
// result is in the output register.
// Reset clears the stack pointer and handshake state; stack memory is not cleared.
`default_nettype none

module integer_stack_machine_top
    import ism_pkg::*;
#(
    parameter int STACK_DEPTH = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // func[3:0], value[35:4], zero fill
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata   // top_value[31:0], stack_depth[42:32],
                                       // error_code[44:43], zero fill
);

    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    state_t            state_reg, state_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [DATA_W-1:0] top_reg, top_next;
    logic [3:0]        op_reg, op_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [1:0]        err_reg, err_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [47:0]       m_tdata_reg, m_tdata_next;

    logic [SP_W-1:0]   sp_m1;
    logic [SP_W-1:0]   sp_m2;
    logic [SP_W+10:0]  sp_ext;
    logic              has1;
    logic              has2;
    logic              full;
    logic [DATA_W-1:0] nos;
    logic [DATA_W-1:0] product;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    div_req_t          div_req;
    div_rsp_t          div_rsp;

    ism_stack_ram #(
        .DEPTH  (STACK_DEPTH),
        .ADDR_W (ADDR_W),
        .WIDTH  (DATA_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (nos)
    );

    ism_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // The top entry lives in top_reg; memory holds the entries below it.
    assign sp_m1   = sp_reg - SP_W'(1);
    assign sp_m2   = sp_reg - SP_W'(2);
    assign sp_ext  = {11'b0, sp_reg};
    assign has1    = (sp_reg != '0);
    assign has2    = (sp_reg >= SP_W'(2));
    assign full    = (sp_reg >= SP_W'(STACK_DEPTH));
    assign product = top_reg * nos;

    assign s_tready = (state_reg == S_IDLE);
    assign rd_en    = s_tvalid && s_tready;
    assign rd_addr  = sp_m2[ADDR_W-1:0];
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        state_next    = state_reg;
        sp_next       = sp_reg;
        top_next      = top_reg;
        op_next       = op_reg;
        val_next      = val_reg;
        err_next      = err_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        wr_en         = 1'b0;
        wr_addr       = sp_m1[ADDR_W-1:0];
        wr_data       = top_reg;
        div_req.start = 1'b0;
        div_req.num   = top_reg;
        div_req.den   = nos;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = s_tdata[3:0];
                    val_next   = s_tdata[35:4];
                    err_next   = ERR_OK;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_RESP;
                case (op_reg)
                    OP_CONST:
                    begin
                        if (full)
                        begin
                            err_next = ERR_OVER;
                        end
                        else
                        begin
                            wr_en    = has1;
                            top_next = val_reg;
                            sp_next  = sp_reg + SP_W'(1);
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_MAX, OP_MIN:
                    begin
                        if (!has2)
                        begin
                            err_next = ERR_UNDER;
                        end
                        else
                        begin
                            sp_next = sp_m1;
                            case (op_reg)
                                OP_ADD:  top_next = top_reg + nos;
                                OP_SUB:  top_next = top_reg - nos;
                                OP_MUL:  top_next = product;
                                OP_MAX:  top_next = ($signed(top_reg) > $signed(nos))
                                                    ? top_reg : nos;
                                default: top_next = ($signed(top_reg) > $signed(nos))
                                                    ? nos : top_reg;
                            endcase
                        end
                    end
                    OP_DIV:
                    begin
                        if (!has2)
                        begin
                            err_next = ERR_UNDER;
                        end
                        else if (nos == '0)
                        begin
                            err_next = ERR_DIVZERO;
                        end
                        else
                        begin
                            div_req.start = 1'b1;
                            state_next    = S_DIV;
                        end
                    end
                    OP_NEG:
                    begin
                        if (!has1)
                        begin
                            err_next = ERR_UNDER;
                        end
                        else
                        begin
                            top_next = ~top_reg + 1'b1;
                        end
                    end
                    OP_DUP:
                    begin
                        if (!has1)
                        begin
                            err_next = ERR_UNDER;
                        end
                        else if (full)
                        begin
                            err_next = ERR_OVER;
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            sp_next = sp_reg + SP_W'(1);
                        end
                    end
                    OP_SWAP:
                    begin
                        if (!has2)
                        begin
                            err_next = ERR_UNDER;
                        end
                        else
                        begin
                            wr_en    = 1'b1;
                            wr_addr  = sp_m2[ADDR_W-1:0];
                            top_next = nos;
                        end
                    end
                    default:
                    begin
                        // Undefined opcodes leave the stack alone and report no error.
                        err_next = ERR_OK;
                    end
                endcase
            end

            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    top_next   = div_rsp.quot;
                    sp_next    = sp_m1;
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b0, err_reg, sp_ext[10:0],
                                     has1 ? top_reg : {DATA_W{1'b0}}};
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            sp_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            sp_reg       <= sp_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg     <= top_next;
        op_reg      <= op_next;
        val_reg     <= val_next;
        err_reg     <= err_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

`default_nettype wire
